FILE: rtl/ndmc_pkg.sv
// ----------------------------------------------------------------------------
// ndmc_pkg
// Shared widths and constants for the minimum cost packing unit.
// ----------------------------------------------------------------------------
package ndmc_pkg;
  localparam int DEF_VALUE_BITS = 31;
  localparam int OUT_BITS = 31;
  localparam int EUCLID_STEPS = 64;
  localparam int STEP_BITS = 7;
endpackage

FILE: rtl/nonneg_diophantine_min_cost_unit.sv
// ----------------------------------------------------------------------------
// nonneg_diophantine_min_cost_unit
// Exact two-box packing at least cost by extended Euclid.
// ----------------------------------------------------------------------------
// The Euclid loop does one division per step (at most 46 for 31-bit sizes,
// capped at 64), then eight more divisions follow with the multiply and update
// steps between them. All of these use the single 64-bit serial divider and the
// one 32x32 multiplier shared by every step.
// One transaction at a time; stall is high while busy or while a result waits.
// Reset (synchronous, active high) returns the sequencer to idle.
module nonneg_diophantine_min_cost_unit import ndmc_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] total,
  input  logic [VALUE_BITS-1:0] first_cost,
  input  logic [VALUE_BITS-1:0] first_size,
  input  logic [VALUE_BITS-1:0] second_cost,
  input  logic [VALUE_BITS-1:0] second_size,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  failed,
  output logic [OUT_BITS-1:0]   first_count,
  output logic [OUT_BITS-1:0]   second_count
);
  typedef enum logic [3:0] {
    IDLE, EU_DIV, EU_UPD, TOT_DIV, M1_DIV, M2_DIV, CO_DIV, TR_DIV,
    X_MUL, X_DIV, REST, Y_DIV, K_DIV, K_MUL, OUT
  } state_t;

  state_t state;
  logic [63:0] tt, c1, c2, n1, n2, r0, r1, m1, m2, td, xr, x, y, cost1;
  logic signed [63:0] s0, s1;
  logic [STEP_BITS-1:0] step;
  logic        dstart, ddone;
  logic [63:0] da, db, dq, dr;
  logic [31:0] ma, mb;
  logic [63:0] mp;

  ndmc_divider #(.W(64)) u_div (
    .clk(clk), .rst(rst), .start(dstart), .dividend(da), .divisor(db),
    .done(ddone), .quot(dq), .rem(dr)
  );

  assign in_stall = (state != IDLE);
  assign mp = ma * mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      out_valid <= 1'b0;
      dstart <= 1'b0;
    end else begin
      dstart <= 1'b0;
      unique case (state)
        IDLE: if (in_valid) begin
          tt <= 64'(total); c1 <= 64'(first_cost); n1 <= 64'(first_size);
          c2 <= 64'(second_cost); n2 <= 64'(second_size);
          r0 <= 64'(first_size); r1 <= 64'(second_size);
          s0 <= 64'sd1; s1 <= '0; step <= '0;
          if (first_size == '0 || second_size == '0) begin
            failed <= 1'b1; first_count <= '0; second_count <= '0;
            out_valid <= 1'b1; state <= OUT;
          end else begin
            da <= 64'(first_size); db <= 64'(second_size);
            dstart <= 1'b1; state <= EU_DIV;
          end
        end
        EU_DIV: if (ddone) begin
          ma <= dq[31:0];
          mb <= s1[63] ? 32'(-s1) : 32'(s1);
          state <= EU_UPD;
        end
        EU_UPD: begin
          r0 <= r1; r1 <= dr; s0 <= s1;
          s1 <= s1[63] ? s0 + $signed(mp) : s0 - $signed(mp);
          step <= step + 1'b1;
          if (dr != '0 && step != STEP_BITS'(EUCLID_STEPS - 1)) begin
            da <= r1; db <= dr; dstart <= 1'b1; state <= EU_DIV;
          end else begin
            da <= tt; db <= r1; dstart <= 1'b1; state <= TOT_DIV;
          end
        end
        TOT_DIV: if (ddone) begin
          if (dr != '0) begin
            failed <= 1'b1; first_count <= '0; second_count <= '0;
            out_valid <= 1'b1; state <= OUT;
          end else begin
            td <= dq; da <= n2; db <= r0; dstart <= 1'b1; state <= M1_DIV;
          end
        end
        M1_DIV: if (ddone) begin
          m1 <= dq; da <= n1; db <= r0; dstart <= 1'b1; state <= M2_DIV;
        end
        M2_DIV: if (ddone) begin
          m2 <= dq;
          da <= s0[63] ? 64'(-s0) : 64'(s0); db <= m1;
          dstart <= 1'b1; state <= CO_DIV;
        end
        CO_DIV: if (ddone) begin
          xr <= (s0[63] && dr != '0) ? m1 - dr : dr;
          da <= td; db <= m1; dstart <= 1'b1; state <= TR_DIV;
        end
        TR_DIV: if (ddone) begin
          ma <= xr[31:0]; mb <= dr[31:0]; state <= X_MUL;
        end
        X_MUL: begin
          da <= mp; db <= m1; dstart <= 1'b1; state <= X_DIV;
        end
        X_DIV: if (ddone) begin
          x <= dr; ma <= dr[31:0]; mb <= n1[31:0]; state <= REST;
        end
        REST: begin
          if (mp > tt) begin
            failed <= 1'b1; first_count <= '0; second_count <= '0;
            out_valid <= 1'b1; state <= OUT;
          end else begin
            da <= tt - mp; db <= n2; dstart <= 1'b1; state <= Y_DIV;
            ma <= m1[31:0]; mb <= c1[31:0];
          end
        end
        Y_DIV: if (ddone) begin
          y <= dq;
          cost1 <= mp;
          ma <= m2[31:0]; mb <= c2[31:0];
          da <= dq; db <= m2; dstart <= 1'b1; state <= K_DIV;
        end
        K_DIV: if (ddone) begin
          failed <= 1'b0;
          if (cost1 < mp) begin
            ma <= dq[31:0]; mb <= m1[31:0];
            second_count <= OUT_BITS'(dr);
            state <= K_MUL;
          end else begin
            first_count <= OUT_BITS'(x);
            second_count <= OUT_BITS'(y);
            out_valid <= 1'b1; state <= OUT;
          end
        end
        K_MUL: begin
          first_count <= OUT_BITS'(x + mp);
          out_valid <= 1'b1; state <= OUT;
        end
        OUT: if (!out_stall) begin
          out_valid <= 1'b0; state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/ndmc_divider.sv
// ----------------------------------------------------------------------------
// ndmc_divider
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ndmc_divider import ndmc_pkg::*; #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);
  localparam int CW = $clog2(W + 1);
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W-1:0]  dvs;
  logic [W:0]    trial;

  assign trial = {rem, quot[W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
        quot <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        if (trial[W]) begin
          rem  <= {rem[W-2:0], quot[W-1]};
          quot <= {quot[W-2:0], 1'b0};
        end else begin
          rem  <= trial[W-1:0];
          quot <= {quot[W-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: rtl/ndmc_checker.sv
// ----------------------------------------------------------------------------
// ndmc_checker
// Port-level checks for the minimum cost packing unit.
// ----------------------------------------------------------------------------
module ndmc_checker import ndmc_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic                failed,
  input logic [OUT_BITS-1:0] first_count,
  input logic [OUT_BITS-1:0] second_count
);
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && failed |-> first_count == '0 && second_count == '0)
    else $error("failed result with nonzero counts");
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open while result waits");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(first_count))
    else $error("stalled result changed");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("not busy after accept");
endmodule

bind nonneg_diophantine_min_cost_unit ndmc_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .failed(failed),
  .first_count(first_count), .second_count(second_count)
);
